// ===== sv/dual_quadrature_odometry_top_defines.svh =====
// Assertion macros for the dual quadrature odometry block.
// Used by the port checker; no other dependencies.
`ifndef DUAL_QUADRATURE_ODOMETRY_TOP_DEFINES_SVH
`define DUAL_QUADRATURE_ODOMETRY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DQO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dqo_pkg.sv =====
// Shared types and constants for the dual quadrature odometry block.
// No dependencies.
package dqo_pkg;

  localparam int CNT_W      = 16;
  localparam int S_W        = 17;
  localparam int DT_W       = 16;
  localparam int SCALE_W    = 27;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 27'd128000000;
  localparam int NUM_W      = 44;
  localparam int DIFF_W     = 46;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = DIFF_W + GAIN_W;
  localparam int SPEED_W    = 24;
  localparam int ODO_W      = 32;
  localparam int VSUM_W     = 48;
  localparam int ROUND_SHIFT = 16;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int MUL_CNT_W  = $clog2(GAIN_W);
  localparam logic [DT_W-1:0] DT_MIN = 16'd10;

  localparam int FILTER_LEN_RST = 250;
  localparam int SPEED_GAIN_RST = 9830;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 2'd2;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_POLL   = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_ROUND,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic sample;
    logic clr;
    logic load;
    logic scale;
    logic div_step;
    logic diff;
    logic mul_step;
    logic round;
    logic update;
    logic emit;
  } dqo_cmd_t;

  typedef struct packed {
    logic upd;
    logic div_last;
    logic mul_last;
  } dqo_status_t;

endpackage

// ===== sv/dual_quadrature_odometry_top.sv =====
// Dual 4x quadrature decoder with glitch filters and polled odometry.
// Input channel: func_i selects a pin sample, a poll or a reset command;
// each item is one transfer with in_valid_i high and in_stall_o low.
// Pin samples and reset commands give no result and do not stall, so
// samples stream at one per clock while no poll is running.
// A poll gives one result on the output channel. With dt_us_i above 10 it
// runs scale, a 44-step restoring divide, diff, a 16-step shift-add
// multiply, round and update before the result goes out. With a short
// interval it goes from scale straight to the output step.
// in_stall_o is high from a poll transfer until its result sits in the
// output register.
// The output register holds its result while out_stall_i is high; samples
// are still taken meanwhile, and a following poll waits in its last step.
// Configuration writes are registered through cfg_we_i; write only
// while idle.
// Reset clears filters, counters, travel, speed and restores the default
// register values; no clearing pass is needed.
module dual_quadrature_odometry_top import dqo_pkg::*; #(
  parameter int COUNT_LIMIT = 30000,
  parameter int FILTER_BITS = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic                      a_track1_i,
  input  logic                      a_track2_i,
  input  logic                      b_track1_i,
  input  logic                      b_track2_i,
  input  logic [DT_W-1:0]           dt_us_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ODO_W-1:0]   odometer_o,
  output logic signed [SPEED_W-1:0] velocity_o,
  output logic                      speed_updated_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int FL_W = (FILTER_BITS > 8) ? FILTER_BITS : 8;

  logic [FL_W-1:0]         filter_len_q;
  logic                    invert_b_q;
  logic [GAIN_W-1:0]       speed_gain_q;
  dqo_cmd_t                cmd;
  dqo_status_t             status;
  logic                    busy;
  logic signed [CNT_W-1:0] count_a, count_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_len_q <= FL_W'(FILTER_LEN_RST);
      invert_b_q   <= 1'b0;
      speed_gain_q <= GAIN_W'(SPEED_GAIN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILTER_LEN: filter_len_q <= FL_W'(cfg_data_i[FILTER_BITS-1:0]);
        REG_INVERT_B:   invert_b_q   <= cfg_data_i[0];
        REG_SPEED_GAIN: speed_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  dqo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  dqo_edge #(
    .COUNT_LIMIT (COUNT_LIMIT),
    .FILTER_BITS (FILTER_BITS)
  ) u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .raw_i        ({b_track2_i, b_track1_i, a_track2_i, a_track1_i}),
    .filter_len_i (filter_len_q),
    .count_a_o    (count_a),
    .count_b_o    (count_b)
  );

  dqo_poll u_poll (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .invert_b_i      (invert_b_q),
    .speed_gain_i    (speed_gain_q),
    .dt_us_i         (dt_us_i),
    .count_a_i       (count_a),
    .count_b_i       (count_b),
    .status_o        (status),
    .odometer_o      (odometer_o),
    .velocity_o      (velocity_o),
    .speed_updated_o (speed_updated_o)
  );

  assign in_stall_o = busy;

endmodule

// ===== sv/dqo_edge.sv =====
// Glitch filters on the four tracks and the two saturating edge counters.
// Depends on dqo_pkg.
module dqo_edge import dqo_pkg::*; #(
  parameter int COUNT_LIMIT = 30000,
  parameter int FILTER_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dqo_cmd_t                cmd_i,
  input  logic [3:0]              raw_i,
  input  logic [((FILTER_BITS > 8) ? FILTER_BITS : 8)-1:0] filter_len_i,
  output logic signed [CNT_W-1:0] count_a_o,
  output logic signed [CNT_W-1:0] count_b_o
);

  localparam int FL_W = (FILTER_BITS > 8) ? FILTER_BITS : 8;
  localparam logic signed [CNT_W:0] LIM_P = (CNT_W+1)'(COUNT_LIMIT);
  localparam logic signed [CNT_W:0] LIM_N = -LIM_P;

  logic [3:0]                        level_q, level_d;
  logic [3:0][FILTER_BITS-1:0]       cnt_q, cnt_d;
  logic [3:0]                        chg;
  logic signed [CNT_W-1:0]           count_a_q, count_a_d, count_b_q, count_b_d;
  logic signed [2:0]                 delta_a, delta_b;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chg[i]     = 1'b0;
      level_d[i] = level_q[i];
      cnt_d[i]   = cnt_q[i];
      if (raw_i[i] == level_q[i]) begin
        cnt_d[i] = '0;
      end else if ((filter_len_i == '0) ||
                   (({1'b0, FL_W'(cnt_q[i])} + (FL_W+1)'(1)) >= {1'b0, filter_len_i})) begin
        chg[i]     = 1'b1;
        level_d[i] = raw_i[i];
        cnt_d[i]   = '0;
      end else begin
        cnt_d[i] = cnt_q[i] + FILTER_BITS'(1);
      end
    end
  end

  // Track 1 counts up when its new level equals the other track's old level;
  // track 2 counts up when its new level differs from the other's old level.
  function automatic logic signed [2:0] edge_delta(input logic c1, input logic c2,
                                                   input logic n1, input logic n2,
                                                   input logic o1, input logic o2);
    logic signed [2:0] d;
    d = 3'sd0;
    if (c1) d = d + ((n1 == o2) ? 3'sd1 : -3'sd1);
    if (c2) d = d + ((n2 != o1) ? 3'sd1 : -3'sd1);
    return d;
  endfunction

  function automatic logic signed [CNT_W-1:0] sat_add(input logic signed [CNT_W-1:0] c,
                                                      input logic signed [2:0] d);
    logic signed [CNT_W:0] s;
    s = {c[CNT_W-1], c} + {{(CNT_W-2){d[2]}}, d};
    if (s > LIM_P) s = LIM_P;
    else if (s < LIM_N) s = LIM_N;
    return s[CNT_W-1:0];
  endfunction

  always_comb begin
    delta_a = edge_delta(chg[0], chg[1], level_d[0], level_d[1], level_q[0], level_q[1]);
    delta_b = edge_delta(chg[2], chg[3], level_d[2], level_d[3], level_q[2], level_q[3]);
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    if (cmd_i.clr || cmd_i.load) begin
      count_a_d = '0;
      count_b_d = '0;
    end else if (cmd_i.sample) begin
      count_a_d = sat_add(count_a_q, delta_a);
      count_b_d = sat_add(count_b_q, delta_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      cnt_q     <= '0;
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      if (cmd_i.sample) begin
        level_q <= level_d;
        cnt_q   <= cnt_d;
      end
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
    end
  end

  assign count_a_o = count_a_q;
  assign count_b_o = count_b_q;

endmodule

// ===== sv/dqo_poll.sv =====
// Poll datapath: travel accumulator, scaled speed divider, low-pass multiply
// and the result register. Depends on dqo_pkg.
module dqo_poll import dqo_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dqo_cmd_t                  cmd_i,
  input  logic                      invert_b_i,
  input  logic [GAIN_W-1:0]         speed_gain_i,
  input  logic [DT_W-1:0]           dt_us_i,
  input  logic signed [CNT_W-1:0]   count_a_i,
  input  logic signed [CNT_W-1:0]   count_b_i,
  output dqo_status_t               status_o,
  output logic signed [ODO_W-1:0]   odometer_o,
  output logic signed [SPEED_W-1:0] velocity_o,
  output logic                      speed_updated_o
);

  localparam logic signed [VSUM_W-1:0] SPEED_MAX = VSUM_W'((1 << (SPEED_W-1)) - 1);
  localparam logic signed [VSUM_W-1:0] SPEED_MIN = -SPEED_MAX - VSUM_W'(1);

  logic signed [S_W-1:0]     s_q;
  logic                      neg_q;
  logic [DT_W-1:0]           dt_q;
  logic                      upd_q;
  logic [ODO_W-1:0]          travel_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [DT_W-1:0]           rem_q;
  logic [NUM_W-1:0]          quo_q;
  logic [DIV_CNT_W-1:0]      div_cnt_q;
  logic                      dneg_q;
  logic [PROD_W-1:0]         mcand_q, acc_q;
  logic [GAIN_W-1:0]         gain_q;
  logic [MUL_CNT_W-1:0]      mul_cnt_q;
  logic [DIFF_W-1:0]         rmag_q;
  logic [ODO_W-1:0]          odo_q;
  logic signed [SPEED_W-1:0] vel_q;
  logic                      updo_q;

  logic signed [S_W-1:0]     db, s_sum, half;
  logic [S_W-1:0]            s_mag;
  logic [NUM_W-1:0]          num;
  logic [DT_W:0]             rem_sh, rem_sub;
  logic signed [DIFF_W-1:0]  t;
  logic signed [VSUM_W-1:0]  vsum;
  logic [PROD_W-1:0]         acc_rnd;

  always_comb begin
    db     = invert_b_i ? -{count_b_i[CNT_W-1], count_b_i}
                        :  {count_b_i[CNT_W-1], count_b_i};
    s_sum  = {count_a_i[CNT_W-1], count_a_i} + db;
    // truncate toward zero
    half   = (s_sum + signed'(S_W'(s_sum[S_W-1]))) >>> 1;
    s_mag  = s_q[S_W-1] ? S_W'(-s_q) : S_W'(s_q);
    num    = NUM_W'(s_mag) * NUM_W'(SPEED_SCALE) + NUM_W'(dt_q >> 1);
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dt_q};
    t      = neg_q ? (DIFF_W'(quo_q) + DIFF_W'(speed_q))
                   : (DIFF_W'(quo_q) - DIFF_W'(speed_q));
    acc_rnd = acc_q + PROD_W'(1 << (ROUND_SHIFT-1));
    vsum   = dneg_q ? (VSUM_W'(speed_q) - VSUM_W'(rmag_q))
                    : (VSUM_W'(speed_q) + VSUM_W'(rmag_q));
    if (vsum > SPEED_MAX) vsum = SPEED_MAX;
    else if (vsum < SPEED_MIN) vsum = SPEED_MIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travel_q  <= '0;
      speed_q   <= '0;
      upd_q     <= 1'b0;
      div_cnt_q <= '0;
      mul_cnt_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        travel_q <= '0;
        speed_q  <= '0;
      end
      if (cmd_i.load) begin
        travel_q <= travel_q + ODO_W'(unsigned'(ODO_W'(half)));
        upd_q    <= dt_us_i > DT_MIN;
      end
      if (cmd_i.scale) div_cnt_q <= '0;
      else if (cmd_i.div_step) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (cmd_i.diff) mul_cnt_q <= '0;
      else if (cmd_i.mul_step) mul_cnt_q <= mul_cnt_q + MUL_CNT_W'(1);
      if (cmd_i.update) speed_q <= vsum[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q  <= s_sum;
      dt_q <= dt_us_i;
    end
    if (cmd_i.scale) begin
      neg_q <= s_q[S_W-1];
      quo_q <= num;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      // restoring step: one quotient bit
      if (!rem_sub[DT_W]) begin
        rem_q <= rem_sub[DT_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DT_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.diff) begin
      dneg_q  <= neg_q ^ t[DIFF_W-1];
      mcand_q <= PROD_W'(t[DIFF_W-1] ? DIFF_W'(-t) : DIFF_W'(t));
      gain_q  <= speed_gain_i;
      acc_q   <= '0;
    end
    if (cmd_i.mul_step) begin
      if (gain_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q <= mcand_q << 1;
      gain_q  <= gain_q >> 1;
    end
    if (cmd_i.round) rmag_q <= acc_rnd[ROUND_SHIFT +: DIFF_W];
    if (cmd_i.emit) begin
      odo_q  <= travel_q;
      vel_q  <= speed_q;
      updo_q <= upd_q;
    end
  end

  assign status_o.upd      = upd_q;
  assign status_o.div_last = div_cnt_q == DIV_CNT_W'(NUM_W-1);
  assign status_o.mul_last = mul_cnt_q == MUL_CNT_W'(GAIN_W-1);

  assign odometer_o      = signed'(odo_q);
  assign velocity_o      = vel_q;
  assign speed_updated_o = updo_q;

endmodule

// ===== sv/dqo_ctrl.sv =====
// Controller: sequences a poll through scale, divide, multiply and update,
// and owns the output valid flag. Depends on dqo_pkg.
module dqo_ctrl import dqo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  func_i,
  input  logic        out_stall_i,
  input  dqo_status_t status_i,
  output dqo_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        out_valid_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i && func_i == FUNC_POLL) state_d = ST_SCALE;
      ST_SCALE:  state_d = status_i.upd ? ST_DIV : ST_DONE;
      ST_DIV:    if (status_i.div_last) state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_MUL;
      ST_MUL:    if (status_i.mul_last) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE:   if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.sample = func_i == FUNC_SAMPLE;
          cmd_o.load   = func_i == FUNC_POLL;
          cmd_o.clr    = func_i == FUNC_RESET;
        end
      end
      ST_SCALE:  cmd_o.scale    = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_DIFF:   cmd_o.diff     = 1'b1;
      ST_MUL:    cmd_o.mul_step = 1'b1;
      ST_ROUND:  cmd_o.round    = 1'b1;
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_DONE:   cmd_o.emit     = slot_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign busy_o      = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/dqo_checker.sv =====
// Port-level checks for the dual quadrature odometry block, bound to the top.
// Depends on dqo_pkg and the block's assertion macros.
`include "dual_quadrature_odometry_top_defines.svh"

module dqo_checker import dqo_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [1:0]                func_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [ODO_W-1:0]   odometer_o,
  input logic signed [SPEED_W-1:0] velocity_o
);

  logic poll_xfer, sample_xfer, out_held;

  assign poll_xfer   = in_valid_i && !in_stall_o && (func_i == FUNC_POLL);
  assign sample_xfer = in_valid_i && !in_stall_o && (func_i == FUNC_SAMPLE);
  assign out_held    = out_valid_o && out_stall_i;

  `DQO_ASSERT_NEXT(a_poll_busy, clk_i, rst_ni, poll_xfer, in_stall_o, "poll did not stall input")
  `DQO_ASSERT_NEXT(a_sample_free, clk_i, rst_ni, sample_xfer, !in_stall_o, "sample stalled input")
  `DQO_ASSERT_NOW(a_result_from_poll, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without poll")
  `DQO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(odometer_o) && $stable(velocity_o), "held result changed")

endmodule

bind dual_quadrature_odometry_top dqo_checker u_dqo_checker (.*);

// ===== sim/tb.sv =====
// Testbench for dual_quadrature_odometry_top: directed edge, filter and saturation
// cases, then random walks and noise, checked against an in-bench odometry predictor.
// Depends on dqo_pkg and the block's RTL only.
module tb;
  import dqo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0]           FUNC_UNUSED = 2'd3;
  localparam int     COUNT_MAX    = 30000;
  localparam longint SPEED_HI     = 64'sd8388607;
  localparam longint SPEED_LO     = -64'sd8388608;
  localparam longint RATE_SCALE   = 64'sd128000000;
  localparam int     DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [ODO_W-1:0]   odo;
    logic signed [SPEED_W-1:0] vel;
    logic                      upd;
  } reading_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            func_i      = FUNC_SAMPLE;
  logic                  a_track1_i  = 1'b0;
  logic                  a_track2_i  = 1'b0;
  logic                  b_track1_i  = 1'b0;
  logic                  b_track2_i  = 1'b0;
  logic [DT_W-1:0]       dt_us_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [ODO_W-1:0]   odometer_o;
  logic signed [SPEED_W-1:0] velocity_o;
  logic                  speed_updated_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_FILTER_LEN;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  dual_quadrature_odometry_top i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state and register copies
  bit       trk_level [4] = '{default: 1'b0};
  int       trk_count [4] = '{default: 0};
  int       edge_cnt_a = 0;
  int       edge_cnt_b = 0;
  logic [31:0] travel_sum = '0;
  int       speed_q = 0;
  int       cfg_filter_len = FILTER_LEN_RST;
  bit       cfg_invert_b = 1'b0;
  int       cfg_speed_gain = SPEED_GAIN_RST;

  reading_t pending_readings [$];
  int       n_errors = 0;

  // Stimulus state
  int       burst_left = 0;
  bit       no_idle = 1'b0;
  int       ph_a = 0;
  int       ph_b = 0;
  logic [9:0] stall_phase = '0;

  function automatic bit track_filter(input int i, input bit raw);
    if (raw == trk_level[i]) begin
      trk_count[i] = 0;
      return 1'b0;
    end
    if (cfg_filter_len == 0 || trk_count[i] + 1 >= cfg_filter_len) begin
      trk_level[i] = raw;
      trk_count[i] = 0;
      return 1'b1;
    end
    trk_count[i] = (trk_count[i] + 1) & 1023;
    return 1'b0;
  endfunction

  function automatic int encoder_step(input int i, input bit raw1, input bit raw2);
    bit o1, o2, c1, c2;
    int d;
    o1 = trk_level[i];
    o2 = trk_level[i+1];
    c1 = track_filter(i, raw1);
    c2 = track_filter(i + 1, raw2);
    d = 0;
    // sign flips while the other track was low before this sample
    if (c1) d += (trk_level[i] ? 1 : -1) * (o2 ? 1 : -1);
    if (c2) d += (trk_level[i+1] ? -1 : 1) * (o1 ? 1 : -1);
    return d;
  endfunction

  function automatic int clamp_count(input int v);
    if (v > COUNT_MAX) return COUNT_MAX;
    if (v < -COUNT_MAX) return -COUNT_MAX;
    return v;
  endfunction

  function automatic longint div_round(input longint num, input longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void odometry_step(input logic [1:0] fn, input logic [3:0] trk,
                                        input logic [DT_W-1:0] dt);
    int       s;
    longint   raw, stp, v;
    reading_t r;
    case (fn)
      FUNC_SAMPLE: begin
        edge_cnt_a = clamp_count(edge_cnt_a + encoder_step(0, trk[3], trk[2]));
        edge_cnt_b = clamp_count(edge_cnt_b + encoder_step(2, trk[1], trk[0]));
      end
      FUNC_RESET: begin
        edge_cnt_a = 0;
        edge_cnt_b = 0;
        travel_sum = '0;
        speed_q    = 0;
      end
      FUNC_POLL: begin
        s = edge_cnt_a + (cfg_invert_b ? -edge_cnt_b : edge_cnt_b);
        edge_cnt_a = 0;
        edge_cnt_b = 0;
        travel_sum = travel_sum + 32'(s / 2);
        r.upd = 1'b0;
        if (dt > DT_MIN) begin
          raw = div_round(longint'(s) * RATE_SCALE, longint'(dt));
          stp = div_round((raw - speed_q) * cfg_speed_gain, 64'sd65536);
          v = speed_q + stp;
          if (v > SPEED_HI) v = SPEED_HI;
          if (v < SPEED_LO) v = SPEED_LO;
          speed_q = int'(v);
          r.upd = 1'b1;
        end
        r.odo = travel_sum;
        r.vel = SPEED_W'(speed_q);
        pending_readings.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [1:0] gray_code(input int p);
    case (p & 3)
      0:       return 2'b00;
      1:       return 2'b01;
      2:       return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // Send one item in bursts with random gaps; valid stays high across a burst.
  task automatic put_item(input logic [1:0] fn, input logic [3:0] trk,
                          input logic [DT_W-1:0] dt);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!no_idle && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    func_i     <= fn;
    a_track1_i <= trk[3];
    a_track2_i <= trk[2];
    b_track1_i <= trk[1];
    b_track2_i <= trk[0];
    dt_us_i    <= dt;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o === 1'b1);
    odometry_step(fn, trk, dt);
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_FILTER_LEN: cfg_filter_len = int'(val[9:0]);
      REG_INVERT_B:   cfg_invert_b   = val[0];
      REG_SPEED_GAIN: cfg_speed_gain = int'(val);
      default: ;
    endcase
  endtask

  // Advance both encoders along the Gray sequence, holding each step for dwell samples.
  task automatic walk_encoders(input int steps, input int dir_a, input int dir_b,
                               input int dwell);
    for (int i = 0; i < steps; i++) begin
      ph_a = (ph_a + dir_a) & 3;
      ph_b = (ph_b + dir_b) & 3;
      repeat (dwell)
        put_item(FUNC_SAMPLE, {gray_code(ph_a), gray_code(ph_b)}, DT_W'($urandom));
    end
  endtask

  task automatic test_defaults();
    put_item(FUNC_POLL, 4'h0, 16'd0);
    put_item(FUNC_POLL, 4'hF, 16'd10);
    // A steps once and is taken on the last sample; B falls one sample short
    walk_encoders(1, 1, 0, FILTER_LEN_RST);
    walk_encoders(1, 0, 1, FILTER_LEN_RST - 1);
    put_item(FUNC_POLL, 4'h0, 16'hFFFF);
    put_item(FUNC_POLL, 4'h0, 16'd11);
  endtask

  task automatic test_edge_rules();
    quiesce();
    write_reg(REG_FILTER_LEN, 16'd0);
    // both tracks of an encoder changing in one sample
    put_item(FUNC_SAMPLE, 4'b0000, 16'd0);
    put_item(FUNC_SAMPLE, 4'b1111, 16'd0);
    put_item(FUNC_SAMPLE, 4'b0000, 16'd0);
    put_item(FUNC_SAMPLE, 4'b0110, 16'd0);
    put_item(FUNC_SAMPLE, 4'b1001, 16'd0);
    put_item(FUNC_SAMPLE, 4'b0000, 16'd0);
    ph_a = 0;
    ph_b = 0;
    walk_encoders(5, 1, 1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd11);
    quiesce();
    write_reg(REG_INVERT_B, 16'hFFFF);
    walk_encoders(3, -1, 1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd1000);
    // odd negative sum truncates towards zero, short interval keeps speed
    walk_encoders(3, 0, 1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd10);
    put_item(FUNC_UNUSED, 4'hF, 16'hFFFF);
    put_item(FUNC_RESET, 4'hA, 16'h5555);
    put_item(FUNC_POLL, 4'h5, 16'd12);
    quiesce();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_INVERT_B, 16'hFFFE);
  endtask

  task automatic test_filter_extremes();
    quiesce();
    write_reg(REG_FILTER_LEN, 16'hFC40);
    // one sample short, a blip back to the old level, then the full length
    walk_encoders(1, 1, 0, 63);
    put_item(FUNC_SAMPLE, {gray_code(ph_a - 1), gray_code(ph_b)}, 16'd0);
    walk_encoders(1, 0, 0, 64);
    put_item(FUNC_POLL, 4'h0, 16'd100);
    quiesce();
    write_reg(REG_FILTER_LEN, 16'd1);
    walk_encoders(4, 1, -1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd11);
    quiesce();
    write_reg(REG_FILTER_LEN, 16'hFC02);
    walk_encoders(3, 1, 1, 2);
    put_item(FUNC_POLL, 4'h0, 16'd5000);
  endtask

  task automatic test_saturation();
    quiesce();
    write_reg(REG_FILTER_LEN, 16'd0);
    write_reg(REG_SPEED_GAIN, 16'hFFFF);
    write_reg(REG_INVERT_B, 16'h0000);
    walk_encoders(40, 1, 1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd11);
    quiesce();
    write_reg(REG_INVERT_B, 16'h0001);
    walk_encoders(40, -1, 1, 1);
    put_item(FUNC_POLL, 4'h0, 16'd11);
    put_item(FUNC_POLL, 4'h0, 16'hFFFF);
  endtask

  task automatic test_random();
    int n, r, filt, dwell_a, dwell_b, dir_a, dir_b;
    logic [3:0]      trk;
    logic [DT_W-1:0] dt;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       filt = 0;
        1:       filt = 1;
        2:       filt = 2;
        3:       filt = 3;
        4:       filt = $urandom_range(0, 8);
        5:       filt = $urandom_range(4, 16);
        default: filt = $urandom_range(0, 5);
      endcase
      quiesce();
      write_reg(REG_FILTER_LEN, 16'(filt));
      write_reg(REG_INVERT_B, 16'(phase & 1));
      write_reg(REG_SPEED_GAIN, (phase == 0) ? 16'hFFFF :
                                (phase == 1) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      no_idle = (phase == 3);
      dwell_a = 1;
      dwell_b = 1;
      dir_a   = 1;
      dir_b   = -1;
      n = 0;
      while (n < 150) begin
        r   = $urandom_range(0, 99);
        trk = 4'($urandom);
        if (r < 8) begin
          case ($urandom_range(0, 7))
            0:       dt = DT_W'($urandom_range(0, 10));
            1:       dt = 16'd11;
            2:       dt = 16'hFFFF;
            default: dt = DT_W'($urandom_range(0, 65535));
          endcase
          put_item(FUNC_POLL, trk, dt);
        end else if (r == 8) begin
          put_item(FUNC_RESET, trk, DT_W'($urandom));
        end else if (r == 9) begin
          // ignored by the block, so not counted
          put_item(FUNC_UNUSED, trk, DT_W'($urandom));
          continue;
        end else if (r < 30) begin
          put_item(FUNC_SAMPLE, trk, DT_W'($urandom));
        end else begin
          dwell_a--;
          if (dwell_a == 0) begin
            if ($urandom_range(0, 7) == 0) dir_a = -dir_a;
            ph_a = (ph_a + dir_a) & 3;
            dwell_a = ((filt == 0) ? 1 : filt) + $urandom_range(0, 2);
          end
          dwell_b--;
          if (dwell_b == 0) begin
            if ($urandom_range(0, 7) == 0) dir_b = -dir_b;
            ph_b = (ph_b + dir_b) & 3;
            dwell_b = ((filt == 0) ? 1 : filt) + $urandom_range(0, 2);
          end
          // keep the odd random sample as a glitch
          if ($urandom_range(0, 15) != 0) trk = {gray_code(ph_a), gray_code(ph_b)};
          put_item(FUNC_SAMPLE, trk, DT_W'($urandom));
        end
        n++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver stall pattern: free, light, heavy, then a regular on-off beat from stall_phase[3]
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 10'd1;
    case (stall_phase[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_phase[3];
    endcase
  end

  always @(posedge clk_i) begin : check_reading
    reading_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result with none expected: odometer %0d velocity %0d updated %0b",
                 $time, odometer_o, velocity_o, speed_updated_o);
        n_errors++;
      end else begin
        want = pending_readings.pop_front();
        if (odometer_o !== want.odo) begin
          $display("%0t: odometer expected %0d, got %0d", $time, want.odo, odometer_o);
          n_errors++;
        end
        if (velocity_o !== want.vel) begin
          $display("%0t: velocity expected %0d, got %0d", $time, want.vel, velocity_o);
          n_errors++;
        end
        if (speed_updated_o !== want.upd) begin
          $display("%0t: speed_updated expected %0b, got %0b", $time, want.upd,
                   speed_updated_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_edge_rules();
    test_filter_extremes();
    test_saturation();
    test_random();
    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pending_readings.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
